/* rtl/packet_deframer_crc_check_defines.svh */
// Assertion macros shared by the deframer RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef PACKET_DEFRAMER_CRC_CHECK_DEFINES_SVH
`define PACKET_DEFRAMER_CRC_CHECK_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PDFC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdfc assertion failed");

// Next-cycle implication, checked outside reset
`define PDFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdfc assertion failed");

`endif

/* rtl/pdfc_pkg.sv */
// Shared types and constants for the datagram deframer with CRC-32 check.
// No dependencies.
package pdfc_pkg;

	localparam int HEADER_BYTES   = 8;
	localparam int OVERHEAD_BYTES = 12;
	localparam int TRAILER_BYTES  = 4;
	localparam int TYPE_SHIFT     = 5;
	localparam int POS_W          = 17;
	localparam int ADDR_W         = 3;

	localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd512;
	localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};

	// Packet type codes
	localparam logic [2:0] PKT_DATA = 3'd1;
	localparam logic [2:0] PKT_ACK  = 3'd2;

	// Register index of the configuration port
	localparam logic [0:0] REG_MAX_PAYLOAD = 1'b0;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_TYPE = 3'd1,
		ST_TOO_LONG = 3'd2,
		ST_CRC_BAD  = 3'd3,
		ST_SIZE_BAD = 3'd4
	} status_t;

	// Datagram state after the current byte is taken in
	typedef struct packed {
		logic [7:0]       first_byte;
		logic [7:0]       seq;
		logic [15:0]      len;
		logic [31:0]      stamp;
		logic [31:0]      trailer;
		logic [31:0]      crc_trl;
		logic [POS_W-1:0] count;
	} dg_t;

	// One result item
	typedef struct packed {
		status_t     status;
		logic [2:0]  ptype;
		logic [4:0]  window;
		logic [7:0]  seqnum;
		logic [15:0] payload_length;
		logic [31:0] timestamp;
		logic [31:0] received_crc;
	} res_t;

endpackage

/* rtl/pdfc_crc_byte.sv */
// Bytewise update of reflected CRC-32, eight shift steps unrolled.
// Depends on pdfc_pkg for the polynomial.
module pdfc_crc_byte
	import pdfc_pkg::*;
(
	input  logic [31:0] crc_in,
	input  logic [7:0]  data,
	output logic [31:0] crc_out
);

	// Fold the byte in, then shift out eight bits
	always_comb begin
		logic [31:0] c;
		c = crc_in ^ {24'd0, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

/* rtl/pdfc_apb_regs.sv */
// APB register block: holds the maximum payload length.
// Depends on pdfc_pkg for the address width and reset value.
module pdfc_apb_regs
	import pdfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [15:0]       max_payload
);

	logic [15:0] max_payload_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Write the register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (wr_en && (paddr[2] == REG_MAX_PAYLOAD)) begin
			max_payload_q <= pwdata[15:0];
		end
	end

	// Read back; an address past the list reads zero
	always_comb begin
		unique case (paddr[2])
			REG_MAX_PAYLOAD: prdata = {16'd0, max_payload_q};
			default:         prdata = 32'd0;
		endcase
	end

	assign max_payload = max_payload_q;

endmodule

/* rtl/pdfc_track.sv */
// Datagram tracker: byte position, header fields, trailer and running CRC.
// Depends on pdfc_pkg and pdfc_crc_byte.
module pdfc_track
	import pdfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       last,
	output dg_t        dg_next
);

	logic [POS_W-1:0] pos_q;
	logic [31:0]      crc_q;
	logic [7:0]       first_q;
	logic [7:0]       seq_q;
	logic [15:0]      len_q;
	logic [31:0]      stamp_q;
	logic [31:0]      trailer_q;
	logic [31:0]      crc_trl_q;

	logic [31:0]      crc_upd;
	logic [31:0]      crc_n;
	logic [POS_W-1:0] trl_start;
	logic             in_header;

	pdfc_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (data_byte),
		.crc_out (crc_upd)
	);

	assign in_header = (pos_q < POS_W'(HEADER_BYTES));
	assign trl_start = POS_W'(HEADER_BYTES) + {1'b0, len_q};

	// Work out the state after this byte
	always_comb begin
		dg_next.first_byte = first_q;
		dg_next.seq        = seq_q;
		dg_next.len        = len_q;
		dg_next.stamp      = stamp_q;
		dg_next.trailer    = trailer_q;
		dg_next.crc_trl    = crc_trl_q;
		crc_n              = crc_q;
		if (in_header) begin
			crc_n = crc_upd;
			case (pos_q[2:0])
				3'd0:    dg_next.first_byte = data_byte;
				3'd1:    dg_next.seq        = data_byte;
				3'd2:    dg_next.len        = {data_byte, len_q[7:0]};
				3'd3:    dg_next.len        = {len_q[15:8], data_byte};
				default: dg_next.stamp = stamp_q | (32'(data_byte) << {pos_q[1:0], 3'd0});
			endcase
		end else if (pos_q < trl_start) begin
			crc_n = crc_upd;
		end else if (pos_q < trl_start + POS_W'(TRAILER_BYTES)) begin
			if (pos_q == trl_start) begin
				dg_next.crc_trl = crc_q;
			end
			dg_next.trailer = {trailer_q[23:0], data_byte};
		end
		dg_next.count = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
	end

	// Advance on each item; clear after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= CRC_INIT;
			first_q   <= '0;
			seq_q     <= '0;
			len_q     <= '0;
			stamp_q   <= '0;
			trailer_q <= '0;
			crc_trl_q <= '0;
		end else if (take) begin
			if (last) begin
				pos_q     <= '0;
				crc_q     <= CRC_INIT;
				first_q   <= '0;
				seq_q     <= '0;
				len_q     <= '0;
				stamp_q   <= '0;
				trailer_q <= '0;
				crc_trl_q <= '0;
			end else begin
				pos_q     <= dg_next.count;
				crc_q     <= crc_n;
				first_q   <= dg_next.first_byte;
				seq_q     <= dg_next.seq;
				len_q     <= dg_next.len;
				stamp_q   <= dg_next.stamp;
				trailer_q <= dg_next.trailer;
				crc_trl_q <= dg_next.crc_trl;
			end
		end
	end

endmodule

/* rtl/packet_deframer_crc_check.sv */
// Top level of the datagram deframer: status decision and result register.
// Depends on pdfc_pkg, pdfc_apb_regs, pdfc_track and the defines header.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  cfg      | psel penable pwrite paddr pwdata prdata  | APB slave
//  in       | in_valid in_ready data_byte last         | sink
//  out      | out_valid out_ready status .. received_crc | source
//
// One byte is taken per cycle while in_ready is high; tracker state and CRC are registered.
// A result appears in the output register the cycle after its last byte.
// Input stalls only while a result is held and out_ready is low.
// Reset gives max_payload 512 and an empty datagram; no clearing pass.
`include "packet_deframer_crc_check_defines.svh"

module packet_deframer_crc_check
	import pdfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [2:0]        ptype,
	output logic [4:0]        window,
	output logic [7:0]        seqnum,
	output logic [15:0]       payload_length,
	output logic [31:0]       timestamp,
	output logic [31:0]       received_crc
);

	logic [15:0]      max_payload;
	logic             take;
	dg_t              dg_next;
	res_t             res_d;
	res_t             res_s1;
	logic             out_valid_q;
	logic [POS_W-1:0] expected;
	logic [2:0]       ptype_d;

	pdfc_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.max_payload (max_payload)
	);

	pdfc_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.last      (last),
		.dg_next   (dg_next)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	assign ptype_d  = dg_next.first_byte[TYPE_SHIFT +: 3];
	assign expected = POS_W'(OVERHEAD_BYTES) + {1'b0, dg_next.len};

	// Decide the status in priority order
	always_comb begin
		if ((ptype_d != PKT_DATA) && (ptype_d != PKT_ACK)) begin
			res_d.status = ST_BAD_TYPE;
		end else if (dg_next.len > max_payload) begin
			res_d.status = ST_TOO_LONG;
		end else if (dg_next.count < expected) begin
			res_d.status = ST_SIZE_BAD;
		end else if (~dg_next.crc_trl != dg_next.trailer) begin
			res_d.status = ST_CRC_BAD;
		end else if (dg_next.count != expected) begin
			res_d.status = ST_SIZE_BAD;
		end else begin
			res_d.status = ST_OK;
		end
		res_d.ptype          = ptype_d;
		res_d.window         = dg_next.first_byte[4:0];
		res_d.seqnum         = dg_next.seq;
		res_d.payload_length = dg_next.len;
		res_d.timestamp      = dg_next.stamp;
		res_d.received_crc   = dg_next.trailer;
	end

	// Hold the result until taken; load on the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last) begin
			res_s1 <= res_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_s1.status;
	assign ptype          = res_s1.ptype;
	assign window         = res_s1.window;
	assign seqnum         = res_s1.seqnum;
	assign payload_length = res_s1.payload_length;
	assign timestamp      = res_s1.timestamp;
	assign received_crc   = res_s1.received_crc;

	`PDFC_ASSERT_NEXT(a_last_gives_result, take && last, out_valid_q)
	`PDFC_ASSERT_IMPL(a_stall_blocks_input, out_valid_q && !out_ready, !in_ready)
	`PDFC_ASSERT_NEXT(a_drain_clears, out_valid_q && out_ready && !(take && last), !out_valid_q)
	`PDFC_ASSERT_IMPL(a_status_code, out_valid_q, status <= 3'(ST_SIZE_BAD))

endmodule

/* tb/sv/packet_deframer_crc_check_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the datagram deframer: follows the byte stream, predicts the
// status and header fields per datagram and compares them with each result item.
// Depends on pdfc_pkg; also holds the small pdfc_tb_pkg CRC helper package.

package pdfc_tb_pkg;
	import pdfc_pkg::*;

	// Reflected CRC-32, one byte, LSB first
	function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction
endpackage

module packet_deframer_crc_check_checker
	import pdfc_pkg::*;
	import pdfc_tb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              last,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [2:0]        status,
	input  logic [2:0]        ptype,
	input  logic [4:0]        window,
	input  logic [7:0]        seqnum,
	input  logic [15:0]       payload_length,
	input  logic [31:0]       timestamp,
	input  logic [31:0]       received_crc,
	output int                mismatch_count,
	output int                results_due
);

	res_t             verdict_q[$];
	logic [15:0]      max_len;
	logic [POS_W-1:0] pos;
	logic [31:0]      crc_acc;
	logic [31:0]      crc_frozen;
	logic [31:0]      stamp_acc;
	logic [31:0]      trailer_acc;
	logic [7:0]       hdr0;
	logic [7:0]       seq_acc;
	logic [15:0]      len_acc;

	// Drop everything gathered for the current datagram
	task automatic restart_frame();
		pos         = '0;
		crc_acc     = CRC_INIT;
		crc_frozen  = '0;
		stamp_acc   = '0;
		trailer_acc = '0;
		hdr0        = '0;
		seq_acc     = '0;
		len_acc     = '0;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Take one byte in; on the last byte decide the status and queue the result
	task automatic take_byte(input logic [7:0] b, input logic fin);
		int   p;
		int   trl_start;
		int   count;
		int   needed;
		res_t r;
		p = int'(pos);
		if (p < HEADER_BYTES) begin
			case (p)
				0: hdr0 = b;
				1: seq_acc = b;
				2: len_acc[15:8] = b;
				3: len_acc[7:0] = b;
				default: stamp_acc |= 32'(b) << (8 * (p - 4));
			endcase
			crc_acc = crc32_byte(crc_acc, b);
		end else begin
			trl_start = HEADER_BYTES + int'(len_acc);
			if (p < trl_start) begin
				crc_acc = crc32_byte(crc_acc, b);
			end else if (p < trl_start + TRAILER_BYTES) begin
				if (p == trl_start)
					crc_frozen = crc_acc;
				trailer_acc = {trailer_acc[23:0], b};
			end
		end
		if (pos != POS_MAX)
			pos++;
		if (fin) begin
			count  = int'(pos);
			needed = OVERHEAD_BYTES + int'(len_acc);
			r.ptype = 3'(hdr0 >> TYPE_SHIFT);
			if (r.ptype != PKT_DATA && r.ptype != PKT_ACK)
				r.status = ST_BAD_TYPE;
			else if (len_acc > max_len)
				r.status = ST_TOO_LONG;
			else if (count < needed)
				r.status = ST_SIZE_BAD;
			else if (~crc_frozen != trailer_acc)
				r.status = ST_CRC_BAD;
			else if (count != needed)
				r.status = ST_SIZE_BAD;
			else
				r.status = ST_OK;
			r.window         = hdr0[4:0];
			r.seqnum         = seq_acc;
			r.payload_length = len_acc;
			r.timestamp      = stamp_acc;
			r.received_crc   = trailer_acc;
			verdict_q.push_back(r);
			restart_frame();
		end
	endtask

	// Follow register writes, then results, then incoming bytes
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			restart_frame();
			max_len = MAX_PAYLOAD_RST;
			verdict_q.delete();
			mismatch_count = 0;
			results_due <= 0;
		end else begin
			if (psel && penable && pwrite && pready &&
					paddr[ADDR_W-1:2] == REG_MAX_PAYLOAD)
				max_len = pwdata[15:0];
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					$error("result item with no datagram outstanding, status 0x%0h", status);
					mismatch_count++;
				end else begin
					want = verdict_q.pop_front();
					compare_field("status", 32'(want.status), 32'(status));
					compare_field("ptype", 32'(want.ptype), 32'(ptype));
					compare_field("window", 32'(want.window), 32'(window));
					compare_field("seqnum", 32'(want.seqnum), 32'(seqnum));
					compare_field("payload_length", 32'(want.payload_length),
						32'(payload_length));
					compare_field("timestamp", want.timestamp, timestamp);
					compare_field("received_crc", want.received_crc, received_crc);
				end
			end
			if (in_valid && in_ready)
				take_byte(data_byte, last);
			results_due <= verdict_q.size();
		end
	end

endmodule

/* tb/sv/packet_deframer_crc_check_tb.sv */
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, byte and register stimulus,
// result back-pressure, watchdog and verdict.
// Depends on pdfc_pkg, pdfc_tb_pkg, the checker module and the deframer RTL.

module packet_deframer_crc_check_tb;
	import pdfc_pkg::*;
	import pdfc_tb_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam logic [ADDR_W-1:0] ADDR_MAX_PAYLOAD = ADDR_W'(4 * REG_MAX_PAYLOAD);
	localparam logic [ADDR_W-1:0] ADDR_SPARE       = ADDR_W'(4);

	typedef enum {
		FR_GOOD, FR_CRC_BAD, FR_TYPE_BAD, FR_TOO_LONG, FR_SHORT, FR_LONG, FR_NOISE
	} frame_kind_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [31:0]       pwdata  = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [7:0]        data_byte = '0;
	logic              last      = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [2:0]        status;
	logic [2:0]        ptype;
	logic [4:0]        window;
	logic [7:0]        seqnum;
	logic [15:0]       payload_length;
	logic [31:0]       timestamp;
	logic [31:0]       received_crc;

	int          mismatch_count;
	int          results_due;
	int          idle_count = 0;
	bit          no_idle    = 1'b0;
	logic [15:0] max_cur    = MAX_PAYLOAD_RST;
	int          bytes_sent = 0;
	int          frames_sent = 0;

	packet_deframer_crc_check u_top (.*);

	packet_deframer_crc_check_checker u_chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort when nothing has moved for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
				idle_count <= 0;
			end else if (idle_count >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				idle_count <= idle_count + 1;
			end
		end
	end

	// Result side: random stall before each item
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Present one byte after a random gap and hold it until taken
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_byte <= b;
		last      <= fin;
		in_valid  <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Build header, payload and trailer, then cut or pad to total bytes (0 keeps it)
	task automatic send_frame(input logic [2:0] ty, input logic [4:0] win,
			input logic [7:0] sq, input logic [15:0] len_f, input logic [31:0] ts,
			input int pay_n, input bit flip, input int total);
		logic [7:0]  q[$];
		logic [31:0] crc;
		logic [31:0] trl;
		q = {};
		q.push_back({ty, win});
		q.push_back(sq);
		q.push_back(len_f[15:8]);
		q.push_back(len_f[7:0]);
		for (int i = 0; i < 4; i++)
			q.push_back(ts[8*i +: 8]);
		repeat (pay_n) q.push_back(8'($urandom));
		crc = CRC_INIT;
		foreach (q[i])
			crc = crc32_byte(crc, q[i]);
		trl = ~crc;
		if (flip)
			trl ^= 32'h1 << $urandom_range(0, 31);
		for (int i = 3; i >= 0; i--)
			q.push_back(trl[8*i +: 8]);
		if (total > 0) begin
			while (q.size() < total)
				q.push_back(8'($urandom));
			while (q.size() > total)
				void'(q.pop_back());
		end
		for (int i = 0; i < q.size(); i++)
			send_byte(q[i], i == q.size() - 1);
		frames_sent++;
	endtask

	// Withdraw the input, then wait until every result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (results_due != 0)
			@(negedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Change the payload limit only once the block has gone quiet
	task automatic set_max(input logic [15:0] val);
		wait_drained();
		repeat (4) @(negedge clk);
		apb_write(ADDR_MAX_PAYLOAD, {16'($urandom), val});
		max_cur = val;
	endtask

	task automatic random_frame();
		frame_kind_t kind;
		int          r;
		int          pay_n;
		int          total;
		int          len_i;
		bit          flip;
		logic [2:0]  ty;
		logic [15:0] len_f;
		r = $urandom_range(0, 99);
		kind = r < 55 ? FR_GOOD : r < 63 ? FR_CRC_BAD : r < 71 ? FR_TYPE_BAD :
			r < 79 ? FR_TOO_LONG : r < 87 ? FR_SHORT : r < 94 ? FR_LONG : FR_NOISE;
		ty = $urandom_range(0, 1) ? PKT_DATA : PKT_ACK;
		pay_n = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 200) : $urandom_range(0, 16);
		if (pay_n > int'(max_cur))
			pay_n = int'(max_cur);
		len_f = 16'(pay_n);
		flip  = 1'b0;
		total = 0;
		case (kind)
			FR_CRC_BAD: flip = 1'b1;
			FR_TYPE_BAD: begin
				do ty = 3'($urandom); while (ty == PKT_DATA || ty == PKT_ACK);
			end
			FR_TOO_LONG: begin
				len_i = int'(max_cur) + 1 + $urandom_range(0, 20);
				if (len_i > 65535)
					len_i = 65535;
				len_f = 16'(len_i);
				if (len_i <= 64) begin
					pay_n = len_i;
				end else begin
					pay_n = 0;
					total = $urandom_range(1, 30);
				end
			end
			FR_SHORT: total = $urandom_range(1, OVERHEAD_BYTES - 1 + pay_n);
			FR_LONG: total = OVERHEAD_BYTES + pay_n + $urandom_range(1, 8);
			FR_NOISE: begin
				ty    = 3'($urandom);
				len_f = 16'($urandom);
				pay_n = 0;
				total = $urandom_range(1, 24);
			end
			default: ;
		endcase
		send_frame(ty, 5'($urandom), 8'($urandom), len_f, $urandom, pay_n, flip, total);
		// Now and then hold off until every result is back
		if ($urandom_range(0, 15) == 0)
			wait_drained();
	endtask

	initial begin
		int          phase_bytes;
		int          phase_frames;
		logic [15:0] phase_max[4];
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: field extremes, every type code, each failure path
		send_frame(PKT_DATA, 5'h00, 8'h00, 16'd0, 32'h0, 0, 1'b0, 0);
		send_frame(PKT_ACK, 5'h1F, 8'hFF, 16'd5, 32'hFFFF_FFFF, 5, 1'b0, 0);
		for (int t = 0; t < 8; t++)
			send_frame(3'(t), 5'($urandom), 8'($urandom), 16'd2, $urandom, 2, 1'b0, 0);
		send_frame(PKT_DATA, 5'($urandom), 8'($urandom), 16'd3, $urandom, 3, 1'b1, 0);
		send_frame(PKT_DATA, 5'($urandom), 8'($urandom), 16'd513, $urandom, 0, 1'b0, 10);
		send_frame(PKT_ACK, 5'($urandom), 8'($urandom), 16'hFFFF, $urandom, 0, 1'b0, 8);
		// Datagrams cut inside the header
		send_frame(PKT_DATA, 5'($urandom), 8'($urandom), 16'd4, $urandom, 4, 1'b0, 1);
		send_frame(PKT_DATA, 5'($urandom), 8'($urandom), 16'd4, $urandom, 4, 1'b0, 3);
		send_frame(PKT_ACK, 5'($urandom), 8'($urandom), 16'd4, $urandom, 4, 1'b0, 7);
		// One byte short of the trailer, then bytes past it
		send_frame(PKT_DATA, 5'($urandom), 8'($urandom), 16'd4, $urandom, 4, 1'b0, 15);
		send_frame(PKT_ACK, 5'($urandom), 8'($urandom), 16'd4, $urandom, 4, 1'b0, 18);

		// Zero payload limit; a write to the unused address must change nothing
		set_max(16'd0);
		send_frame(PKT_DATA, 5'($urandom), 8'($urandom), 16'd0, $urandom, 0, 1'b0, 0);
		send_frame(PKT_DATA, 5'($urandom), 8'($urandom), 16'd1, $urandom, 1, 1'b0, 0);
		send_frame(PKT_ACK, 5'($urandom), 8'($urandom), 16'd0, $urandom, 0, 1'b1, 0);
		wait_drained();
		repeat (4) @(negedge clk);
		apb_write(ADDR_SPARE, 32'h0000_0005);
		send_frame(PKT_DATA, 5'($urandom), 8'($urandom), 16'd3, $urandom, 3, 1'b0, 0);

		// Full limit for a few random datagrams
		set_max(16'hFFFF);
		repeat (4) random_frame();
		wait_drained();

		// Random phases under several limits, one of them without idling
		phase_max[0] = 16'($urandom_range(0, 40));
		phase_max[1] = MAX_PAYLOAD_RST;
		phase_max[2] = 16'($urandom_range(0, 20));
		phase_max[3] = 16'($urandom_range(41, 300));
		for (int ph = 0; ph < 4; ph++) begin
			set_max(phase_max[ph]);
			no_idle = (ph == 2);
			phase_bytes  = bytes_sent;
			phase_frames = frames_sent;
			while (bytes_sent - phase_bytes < 80 || frames_sent - phase_frames < 4)
				random_frame();
		end
		no_idle = 1'b0;

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pdfc_pkg.sv
rtl/pdfc_crc_byte.sv
rtl/pdfc_apb_regs.sv
rtl/pdfc_track.sv
rtl/packet_deframer_crc_check.sv
tb/sv/packet_deframer_crc_check_checker.sv
tb/sv/packet_deframer_crc_check_tb.sv
